### src/mck_pkg.sv
// shared types, codes and the character pattern table of the morse keyer
package mck_pkg;

	localparam int TABLE_ENTRIES = 36;
	localparam int MAX_ELEMENTS  = 5;
	localparam int TICK_W        = 16;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(MAX_ELEMENTS + 1);
	localparam int CFG_IDX_W     = 3;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_WORD = 2'd1,
		KIND_TICK = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DOT        = 3'd0,
		REG_DASH       = 3'd1,
		REG_ELEM_GAP   = 3'd2,
		REG_LETTER_GAP = 3'd3,
		REG_WORD_GAP   = 3'd4
	} reg_idx_t;

	localparam logic [TICK_W-1:0] DOT_RST        = 16'd200;
	localparam logic [TICK_W-1:0] DASH_RST       = 16'd600;
	localparam logic [TICK_W-1:0] ELEM_GAP_RST   = 16'd200;
	localparam logic [TICK_W-1:0] LETTER_GAP_RST = 16'd600;
	localparam logic [TICK_W-1:0] WORD_GAP_RST   = 16'd1400;

	typedef enum logic [4:0] {
		PH_IDLE       = 5'b00001,
		PH_MARK       = 5'b00010,
		PH_ELEM_GAP   = 5'b00100,
		PH_LETTER_GAP = 5'b01000,
		PH_WORD_GAP   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [TICK_W-1:0] dot;
		logic [TICK_W-1:0] dash;
		logic [TICK_W-1:0] elem_gap;
		logic [TICK_W-1:0] letter_gap;
		logic [TICK_W-1:0] word_gap;
	} cfg_t;

	// bit n set means element n is a dash, element 0 is sent first
	typedef struct packed {
		logic [MAX_ELEMENTS-1:0] bits;
		logic [CNT_W-1:0]        count;
	} pattern_t;

	typedef struct packed {
		logic pin_level;
		logic busy;
		logic accepted;
		logic bad_char;
	} result_t;

	localparam pattern_t CODE_TABLE [TABLE_ENTRIES] = '{
		'{5'd2,  3'd2}, '{5'd1,  3'd4}, '{5'd5,  3'd4}, '{5'd1,  3'd3}, // A B C D
		'{5'd0,  3'd1}, '{5'd4,  3'd4}, '{5'd3,  3'd3}, '{5'd0,  3'd4}, // E F G H
		'{5'd0,  3'd2}, '{5'd14, 3'd4}, '{5'd5,  3'd3}, '{5'd2,  3'd4}, // I J K L
		'{5'd3,  3'd2}, '{5'd1,  3'd2}, '{5'd7,  3'd3}, '{5'd6,  3'd4}, // M N O P
		'{5'd11, 3'd4}, '{5'd2,  3'd3}, '{5'd0,  3'd3}, '{5'd1,  3'd1}, // Q R S T
		'{5'd4,  3'd3}, '{5'd8,  3'd4}, '{5'd6,  3'd3}, '{5'd9,  3'd4}, // U V W X
		'{5'd13, 3'd4}, '{5'd3,  3'd4},                                 // Y Z
		'{5'd30, 3'd5}, '{5'd28, 3'd5}, '{5'd24, 3'd5}, '{5'd16, 3'd5}, // 1 2 3 4
		'{5'd0,  3'd5}, '{5'd1,  3'd5}, '{5'd3,  3'd5}, '{5'd7,  3'd5}, // 5 6 7 8
		'{5'd15, 3'd5}, '{5'd31, 3'd5}                                  // 9 0
	};

endpackage

### src/mck_lookup.sv
// ascii code to morse pattern lookup
module mck_lookup (
	input  logic [7:0]        char_code,
	output logic              hit,
	output mck_pkg::pattern_t pattern
);

	logic [mck_pkg::IDX_W-1:0] idx;

	always_comb begin
		hit = 1'b1;
		idx = '0;
		if (char_code inside {[8'h41:8'h5A]}) begin
			// letters A to Z
			idx = mck_pkg::IDX_W'(char_code - 8'h41);
		end else if (char_code inside {[8'h31:8'h39]}) begin
			// digits 1 to 9 follow the letters
			idx = mck_pkg::IDX_W'(char_code - 8'h31 + 8'd26);
		end else if (char_code == 8'h30) begin
			idx = mck_pkg::IDX_W'(mck_pkg::TABLE_ENTRIES - 1);
		end else begin
			hit = 1'b0;
		end
		pattern = mck_pkg::CODE_TABLE[idx];
	end

endmodule

### src/mck_core.sv
// keyer timing state and the per-item update
module mck_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [1:0]          kind,
	input  logic [7:0]          char_code,
	input  mck_pkg::cfg_t       cfg,
	output mck_pkg::result_t    res
);

	mck_pkg::phase_t                 phase_q, phase_d;
	logic [mck_pkg::TICK_W-1:0]      ticks_q, ticks_d;
	logic [mck_pkg::MAX_ELEMENTS-1:0] pattern_q, pattern_d;
	logic [mck_pkg::CNT_W-1:0]       elements_q, elements_d;
	logic                            key_q, key_d;

	logic                            hit;
	mck_pkg::pattern_t               pat;
	logic                            idle;
	logic                            acc;
	logic                            bad;
	logic [mck_pkg::MAX_ELEMENTS-1:0] src_bits;
	logic [mck_pkg::CNT_W-1:0]       src_count;

	mck_lookup u_lookup (
		.char_code (char_code),
		.hit       (hit),
		.pattern   (pat)
	);

	assign idle = (phase_q == mck_pkg::PH_IDLE);

	// pattern source for the next element: fresh table entry when idle
	assign src_bits  = idle ? pat.bits  : pattern_q;
	assign src_count = idle ? pat.count : elements_q;

	always_comb begin
		phase_d    = phase_q;
		ticks_d    = ticks_q;
		pattern_d  = pattern_q;
		elements_d = elements_q;
		key_d      = key_q;
		acc        = 1'b0;
		bad        = 1'b0;
		case (kind)
			mck_pkg::KIND_CHAR: begin
				if (!hit) begin
					bad = 1'b1;
				end else if (idle) begin
					acc        = 1'b1;
					key_d      = 1'b0;
					ticks_d    = pat.bits[0] ? cfg.dash : cfg.dot;
					pattern_d  = src_bits >> 1;
					elements_d = src_count - 1'b1;
					phase_d    = mck_pkg::PH_MARK;
				end
			end
			mck_pkg::KIND_WORD: begin
				if (idle) begin
					acc     = 1'b1;
					key_d   = 1'b1;
					ticks_d = cfg.word_gap;
					phase_d = mck_pkg::PH_WORD_GAP;
				end
			end
			mck_pkg::KIND_TICK: begin
				if (!idle) begin
					// a count of zero or one ends the phase on this tick
					if (ticks_q[mck_pkg::TICK_W-1:1] == '0) begin
						if (phase_q == mck_pkg::PH_MARK) begin
							key_d   = 1'b1;
							ticks_d = cfg.elem_gap;
							phase_d = mck_pkg::PH_ELEM_GAP;
						end else if (phase_q == mck_pkg::PH_ELEM_GAP
							&& elements_q != '0) begin
							key_d      = 1'b0;
							ticks_d    = pattern_q[0] ? cfg.dash : cfg.dot;
							pattern_d  = src_bits >> 1;
							elements_d = src_count - 1'b1;
							phase_d    = mck_pkg::PH_MARK;
						end else if (phase_q == mck_pkg::PH_ELEM_GAP) begin
							key_d   = 1'b1;
							ticks_d = cfg.letter_gap;
							phase_d = mck_pkg::PH_LETTER_GAP;
						end else begin
							key_d   = 1'b1;
							ticks_d = '0;
							phase_d = mck_pkg::PH_IDLE;
						end
					end else begin
						ticks_d = ticks_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.pin_level = key_d;
		res.busy      = (phase_d != mck_pkg::PH_IDLE);
		res.accepted  = acc;
		res.bad_char  = bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= mck_pkg::PH_IDLE;
			ticks_q    <= '0;
			pattern_q  <= '0;
			elements_q <= '0;
			key_q      <= 1'b1;
		end else if (adv) begin
			phase_q    <= phase_d;
			ticks_q    <= ticks_d;
			pattern_q  <= pattern_d;
			elements_q <= elements_d;
			key_q      <= key_d;
		end
	end

	a_idle_key_off: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == mck_pkg::PH_IDLE |-> key_q)
		else $error("key on while idle");

	a_key_on_mark: assert property (@(posedge clk) disable iff (!arst_n)
		!key_q |-> phase_q == mck_pkg::PH_MARK)
		else $error("key on outside a mark");

	a_elem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		elements_q <= mck_pkg::CNT_W'(mck_pkg::MAX_ELEMENTS - 1))
		else $error("element count out of range");

	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		adv && acc |=> phase_q != mck_pkg::PH_IDLE)
		else $error("accepted request left block idle");

	a_bad_hold: assert property (@(posedge clk) disable iff (!arst_n)
		adv && bad |=> $stable(phase_q) && $stable(ticks_q) && $stable(key_q))
		else $error("bad character changed state");

endmodule

### src/morse_code_keyer.sv
// morse keyer top: input register, config registers, result register
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  in       | in_valid / in_ready    | kind, char_code
//  out      | out_valid / out_ready  | pin_level, busy_res, accepted, bad_char
//  cfg      | cfg_we                 | cfg_index, cfg_data
//
// one item per cycle while the output is not stalled; a result passes through
// the input register, then the timing update into the result register
// the timing state advances when an item moves from the input register
// into the result register, so a stalled output holds the state
// reset clears the timing state to idle, key off, and the timing registers
// to their defaults
module morse_code_keyer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        pin_level,
	output logic        busy_res,
	output logic        accepted,
	output logic        bad_char,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic                vld_s1;
	logic [1:0]          kind_s1;
	logic [7:0]          char_s1;
	logic                vld_s2;
	mck_pkg::result_t    res_s2;
	mck_pkg::result_t    res;
	mck_pkg::cfg_t       cfg_q;
	logic                adv;

	assign adv      = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind;
			char_s1 <= char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dot        <= mck_pkg::DOT_RST;
			cfg_q.dash       <= mck_pkg::DASH_RST;
			cfg_q.elem_gap   <= mck_pkg::ELEM_GAP_RST;
			cfg_q.letter_gap <= mck_pkg::LETTER_GAP_RST;
			cfg_q.word_gap   <= mck_pkg::WORD_GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mck_pkg::REG_DOT:        cfg_q.dot        <= cfg_data;
				mck_pkg::REG_DASH:       cfg_q.dash       <= cfg_data;
				mck_pkg::REG_ELEM_GAP:   cfg_q.elem_gap   <= cfg_data;
				mck_pkg::REG_LETTER_GAP: cfg_q.letter_gap <= cfg_data;
				mck_pkg::REG_WORD_GAP:   cfg_q.word_gap   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mck_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.kind      (kind_s1),
		.char_code (char_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (out_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid = vld_s2;
	assign pin_level = res_s2.pin_level;
	assign busy_res  = res_s2.busy;
	assign accepted  = res_s2.accepted;
	assign bad_char  = res_s2.bad_char;

endmodule
